// ===== rtl/core/sha256_stream_hasher_defines.svh =====
// ---------------------------------------------------------------------------
// SHA-256 stream hasher assertion macros
// Shared property forms clocked on i_clk, disabled in reset.
// ---------------------------------------------------------------------------
`ifndef SHA256_STREAM_HASHER_DEFINES_SVH
`define SHA256_STREAM_HASHER_DEFINES_SVH

// same-cycle implication
`define SHA_AST_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sha256 assertion failed");

// next-cycle implication
`define SHA_AST_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sha256 assertion failed");

`endif

// ===== rtl/core/sha_pkg.sv =====
// ---------------------------------------------------------------------------
// sha_pkg
// Types, constants and round functions for the SHA-256 stream hasher.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package sha_pkg;

    localparam int Rounds = 64;

    typedef logic [15:0][31:0] t_block;

    typedef struct packed {
        t_block blk;
        logic   fin;
    } t_blk_req;

    typedef enum logic [2:0] {
        F_IDLE,
        F_DATA,
        F_PAD80,
        F_ZERO,
        F_LEN
    } t_front_state;

    typedef enum logic [1:0] {
        B_IDLE,
        B_ROUND,
        B_ADD,
        B_OUT
    } t_back_state;

    localparam logic [7:0]  PadByte  = 8'h80;
    localparam logic [5:0]  LenStart = 6'd56;
    localparam logic [5:0]  FillLast = 6'd63;

    localparam logic [31:0] Iv [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] RoundK [Rounds] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] ssig0(input logic [31:0] x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] ssig1(input logic [31:0] x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic logic [31:0] bsig0(input logic [31:0] x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] bsig1(input logic [31:0] x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

endpackage

// ===== rtl/core/sha_if.sv =====
// ---------------------------------------------------------------------------
// sha_in_if / sha_out_if
// Valid/ready channels for message words and digest words.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface sha_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] msg_word;
    logic [2:0]  byte_count;
    logic        last_word;

    modport source (output valid, msg_word, byte_count, last_word, input ready);
    modport sink   (input valid, msg_word, byte_count, last_word, output ready);
endinterface

interface sha_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        digest_last;

    modport source (output valid, digest_word, word_index, digest_last, input ready);
    modport sink   (input valid, digest_word, word_index, digest_last, output ready);
endinterface

// ===== rtl/core/sha_front.sv =====
// ---------------------------------------------------------------------------
// sha_front
// Packs message bytes into the block buffer, counts the bit length and
// appends the padding; hands each full block to the block queue.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sha_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    sha_in_if.sink            i_msg,
    output logic              o_push_valid,
    input  logic              i_push_ready,
    output sha_pkg::t_blk_req o_push
);
    import sha_pkg::*;

    t_front_state r_state, n_state;
    t_block       r_blk, n_blk;
    logic [5:0]   r_fill;
    logic [31:0]  r_word;
    logic [2:0]   r_cnt;
    logic         r_last;
    logic [63:0]  r_bitlen;

    logic         put_en;
    logic [7:0]   put_b;
    logic         put_done;
    logic         accept;
    logic [1:0]   lane;

    assign accept   = i_msg.valid && i_msg.ready;
    assign put_done = put_en && ((r_fill != FillLast) || i_push_ready);
    assign lane     = ~r_fill[1:0];

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            F_IDLE:  if (accept) n_state = F_DATA;
            F_DATA: begin
                if (r_cnt == 3'd0) n_state = r_last ? F_PAD80 : F_IDLE;
            end
            F_PAD80: if (put_done) n_state = F_ZERO;
            F_ZERO:  if (r_fill == LenStart) n_state = F_LEN;
            F_LEN:   if (put_done && r_fill == FillLast) n_state = F_IDLE;
            default: n_state = F_IDLE;
        endcase
    end

    always_comb begin
        put_en      = 1'b0;
        put_b       = 8'h00;
        i_msg.ready = 1'b0;
        unique case (r_state)
            F_IDLE:  i_msg.ready = 1'b1;
            F_DATA: begin
                put_en = (r_cnt != 3'd0);
                put_b  = r_word[31:24];
            end
            F_PAD80: begin
                put_en = 1'b1;
                put_b  = PadByte;
            end
            F_ZERO:  put_en = (r_fill != LenStart);
            F_LEN: begin
                put_en = 1'b1;
                put_b  = r_bitlen[63:56];
            end
            default: put_en = 1'b0;
        endcase
    end

    always_comb begin
        n_blk = r_blk;
        n_blk[r_fill[5:2]][{lane, 3'b000} +: 8] = put_b;
    end

    assign o_push_valid = put_en && (r_fill == FillLast);
    assign o_push.blk   = n_blk;
    assign o_push.fin   = (r_state == F_LEN);

    always_ff @(posedge i_clk) begin
        if (put_done) r_blk <= n_blk;
        if (accept) begin
            r_word <= i_msg.msg_word;
            r_last <= i_msg.last_word;
        end else if (put_done && r_state == F_DATA) begin
            r_word <= {r_word[23:0], 8'h00};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= F_IDLE;
            r_fill   <= '0;
            r_cnt    <= '0;
            r_bitlen <= '0;
        end else begin
            r_state <= n_state;
            if (put_done) r_fill <= r_fill + 6'd1;
            if (accept) begin
                r_cnt <= (i_msg.byte_count > 3'd4) ? 3'd4 : i_msg.byte_count;
            end else if (put_done && r_state == F_DATA) begin
                r_cnt    <= r_cnt - 3'd1;
                r_bitlen <= r_bitlen + 64'd8;
            end else if (put_done && r_state == F_LEN) begin
                // eight shifts leave the counter cleared for the next message
                r_bitlen <= {r_bitlen[55:0], 8'h00};
            end
        end
    end

endmodule

// ===== rtl/core/sha_blk_fifo.sv =====
// ---------------------------------------------------------------------------
// sha_blk_fifo
// Two-entry queue of filled blocks between the packer and the compressor.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sha_blk_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push_valid,
    output logic              o_push_ready,
    input  sha_pkg::t_blk_req i_push,
    output logic              o_pop_valid,
    input  logic              i_pop_ready,
    output sha_pkg::t_blk_req o_pop
);
    import sha_pkg::*;

    t_blk_req   r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       push;
    logic       pop;

    assign o_push_ready = (r_cnt != 2'd2);
    assign o_pop_valid  = (r_cnt != 2'd0);
    assign o_pop        = r_mem[r_rp];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wp] <= i_push;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

// ===== rtl/core/sha_core.sv =====
// ---------------------------------------------------------------------------
// sha_core
// One-round-per-cycle SHA-256 compression with a rolling schedule window;
// drives the digest words after the final block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sha_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_pop_valid,
    output logic              o_pop_ready,
    input  sha_pkg::t_blk_req i_pop,
    sha_out_if.source         o_dig
);
    import sha_pkg::*;

    t_back_state r_state, n_state;
    logic [5:0]  r_rnd;
    logic [2:0]  r_idx;
    logic        r_fin;
    logic [31:0] r_w [16];
    logic [31:0] r_v [8];
    logic [31:0] r_h [8];

    logic [31:0] t1, t2, w_new, ch, maj;
    logic        pop;
    logic        out_acc;

    assign pop     = i_pop_valid && o_pop_ready;
    assign out_acc = o_dig.valid && o_dig.ready;

    assign ch    = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
    assign maj   = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
    assign t1    = r_v[7] + bsig1(r_v[4]) + ch + RoundK[r_rnd] + r_w[0];
    assign t2    = bsig0(r_v[0]) + maj;
    assign w_new = ssig1(r_w[14]) + r_w[9] + ssig0(r_w[1]) + r_w[0];

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_IDLE:  if (pop) n_state = B_ROUND;
            B_ROUND: if (r_rnd == 6'(Rounds - 1)) n_state = B_ADD;
            B_ADD:   n_state = r_fin ? B_OUT : B_IDLE;
            B_OUT:   if (out_acc && r_idx == 3'd7) n_state = B_IDLE;
            default: n_state = B_IDLE;
        endcase
    end

    always_comb begin
        o_pop_ready       = (r_state == B_IDLE);
        o_dig.valid       = (r_state == B_OUT);
        o_dig.digest_word = r_h[r_idx];
        o_dig.word_index  = r_idx;
        o_dig.digest_last = (r_idx == 3'd7);
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            for (int i = 0; i < 16; i++) r_w[i] <= i_pop.blk[i];
            for (int i = 0; i < 8; i++)  r_v[i] <= r_h[i];
            r_fin <= i_pop.fin;
        end else if (r_state == B_ROUND) begin
            for (int i = 0; i < 15; i++) r_w[i] <= r_w[i + 1];
            r_w[15] <= w_new;
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= t1 + t2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_rnd   <= '0;
            r_idx   <= '0;
            for (int i = 0; i < 8; i++) r_h[i] <= Iv[i];
        end else begin
            r_state <= n_state;
            if (pop) r_rnd <= '0;
            else if (r_state == B_ROUND) r_rnd <= r_rnd + 6'd1;
            if (r_state == B_ADD) begin
                for (int i = 0; i < 8; i++) r_h[i] <= r_h[i] + r_v[i];
                r_idx <= '0;
            end else if (out_acc) begin
                r_idx <= r_idx + 3'd1;
                if (r_idx == 3'd7) begin
                    for (int i = 0; i < 8; i++) r_h[i] <= Iv[i];
                end
            end
        end
    end

endmodule

// ===== rtl/core/sha256_stream_hasher.sv =====
// ---------------------------------------------------------------------------
// sha256_stream_hasher
// SHA-256 over a stream of big-endian message words; eight digest words out.
// ---------------------------------------------------------------------------
// A message word is taken while the packer is idle. Its bytes are then
// packed one per cycle and the packer returns to idle; it takes no new word
// until the last one is packed. Each full 64-byte block goes into a
// two-deep queue to the compressor. The compressor loads a block, runs 64
// rounds at one per cycle and then does the chaining add. The packer is the
// slower side, so it sets the sustained rate. The packer also stalls while
// the queue is full. The last word adds padding at one byte per cycle, which
// fills the rest of the current block and, when the length does not fit,
// one more block. After that the eight digest words are presented one per
// accepted request, index 0 first.
`timescale 1ns / 1ps

module sha256_stream_hasher (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sha_in_if.sink    i_msg,
    sha_out_if.source o_dig
);
    import sha_pkg::*;
    `include "sha256_stream_hasher_defines.svh"

    logic     push_valid;
    logic     push_ready;
    t_blk_req push_req;
    logic     pop_valid;
    logic     pop_ready;
    t_blk_req pop_req;

    sha_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_msg        (i_msg),
        .o_push_valid (push_valid),
        .i_push_ready (push_ready),
        .o_push       (push_req)
    );

    sha_blk_fifo u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push       (push_req),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_pop        (pop_req)
    );

    sha_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_valid (pop_valid),
        .o_pop_ready (pop_ready),
        .i_pop       (pop_req),
        .o_dig       (o_dig)
    );

    `SHA_AST_NEXT(a_busy_after_req, i_msg.valid && i_msg.ready, !i_msg.ready)
    `SHA_AST_IMP(a_no_pop_in_digest, o_dig.valid, !(pop_valid && pop_ready))
    `SHA_AST_NEXT(a_digest_step, o_dig.valid && o_dig.ready && !o_dig.digest_last, o_dig.valid && (o_dig.word_index == $past(o_dig.word_index) + 3'd1))

endmodule
